// ----- hw/rtl/ibq_pkg.sv -----
// ============================================================================
// ibq_pkg - shared types and constants for the biquad IIR filter
// Holds default widths, coefficient reset values, register indexes and the
// command word that the controller hands to the datapath.
// ============================================================================
package ibq_pkg;

    // Default widths and fixed-point layout.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF   = 16;
    localparam int STATE_WIDTH_DEF  = 32;
    localparam int STATE_FRAC       = 8;

    // Configuration port layout.
    localparam int CFG_DATA_WIDTH = 32;
    localparam int PADDR_WIDTH    = 5;

    // Coefficient reset values as 16-bit Q2.14 words.
    localparam logic signed [15:0] A1_RESET = -16'sd18725;
    localparam logic signed [15:0] A2_RESET = 16'sd6763;
    localparam logic signed [15:0] B0_RESET = 16'sd1104;
    localparam logic signed [15:0] B1_RESET = 16'sd2210;
    localparam logic signed [15:0] B2_RESET = 16'sd1104;

    // Register indexes on the configuration port (word address).
    typedef enum logic [2:0] {
        REG_FEEDBACK_FIRST  = 3'd0,
        REG_FEEDBACK_SECOND = 3'd1,
        REG_FORWARD_ZERO    = 3'd2,
        REG_FORWARD_FIRST   = 3'd3,
        REG_FORWARD_SECOND  = 3'd4
    } reg_index_t;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_A1W1,
        MUL_A2W2,
        MUL_B1W1,
        MUL_B2W2,
        MUL_B0W
    } mul_sel_t;

    // Accumulator operation for one cycle.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_SUB,
        ACC_LOAD_HALF_ADD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     w_load;
        logic     out_load;
    } ibq_cmd_t;

    // Rescales a Q2.14 reset value to a coefficient of the given width.
    function automatic logic signed [31:0] scale_coef(logic signed [15:0] value, int width);
        logic signed [31:0] wide;
        wide = 32'(value);
        if (width >= 16)
            return wide <<< (width - 16);
        return wide >>> (16 - width);
    endfunction

endpackage

// ----- hw/rtl/ibq_if.sv -----
// ============================================================================
// ibq_if - streaming channels of the biquad IIR filter
// Valid/ready channels for the input sample and for the filtered result.
// ============================================================================
interface ibq_in_if #(
    parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface ibq_out_if #(
    parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           overflow;

    modport source (output valid, output sample_out, output overflow, input ready);
    modport sink   (input valid, input sample_out, input overflow, output ready);
endinterface

// ----- hw/rtl/ibq_ctrl.sv -----
// ============================================================================
// ibq_ctrl - sequencer of the biquad IIR filter
// One-hot state machine that schedules the five products through the shared
// multiplier and owns the input ready and the output valid.
// ============================================================================
module ibq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ibq_pkg::ibq_cmd_t cmd
);
    import ibq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FB2    = 7'b0000010,
        S_FBSUM  = 7'b0000100,
        S_WSAT   = 7'b0001000,
        S_FF0    = 7'b0010000,
        S_FFLAST = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.mul_sel  = MUL_A1W1;
        cmd.acc_op   = ACC_HOLD;
        cmd.w_load   = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.mul_sel = MUL_A1W1;
                    cmd.acc_op  = ACC_LOAD_X;
                    state_next  = S_FB2;
                end
            end
            S_FB2:
            begin
                cmd.mul_sel = MUL_A2W2;
                cmd.acc_op  = ACC_SUB;
                state_next  = S_FBSUM;
            end
            S_FBSUM:
            begin
                cmd.mul_sel = MUL_B1W1;
                cmd.acc_op  = ACC_SUB;
                state_next  = S_WSAT;
            end
            S_WSAT:
            begin
                cmd.mul_sel = MUL_B2W2;
                cmd.acc_op  = ACC_LOAD_HALF_ADD;
                cmd.w_load  = 1'b1;
                state_next  = S_FF0;
            end
            S_FF0:
            begin
                cmd.mul_sel = MUL_B0W;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_FFLAST;
            end
            S_FFLAST:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted word always starts the feedback products.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_FB2)
        else $error("accepted word did not start the sequence");

    // After the delay word is formed, the forward sum steps through S_FF0 and S_FFLAST to S_OUT.
    a_forward_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WSAT |-> ##3 state_reg == S_OUT)
        else $error("forward sum sequence has the wrong length");

    // Loading a result always presents it on the output.
    a_out_presented: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg && state_reg == S_IDLE)
        else $error("loaded result not presented");

endmodule

// ----- hw/rtl/ibq_datapath.sv -----
// ============================================================================
// ibq_datapath - arithmetic of the biquad IIR filter
// Shared multiplier with registered product, accumulator, rounding and
// saturation, the two-word delay line and the output register.
// ============================================================================
module ibq_datapath #(
    parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = ibq_pkg::COEF_WIDTH_DEF,
    parameter int STATE_WIDTH  = ibq_pkg::STATE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ibq_pkg::ibq_cmd_t              cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [COEF_WIDTH-1:0]   a1,
    input  logic signed [COEF_WIDTH-1:0]   a2,
    input  logic signed [COEF_WIDTH-1:0]   b0,
    input  logic signed [COEF_WIDTH-1:0]   b1,
    input  logic signed [COEF_WIDTH-1:0]   b2,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           overflow
);
    import ibq_pkg::*;

    localparam int COEF_FRAC = COEF_WIDTH - 2;
    localparam int SUM_FRAC  = STATE_FRAC + COEF_FRAC;
    localparam int PROD_W    = COEF_WIDTH + STATE_WIDTH;
    localparam int ACC_A     = PROD_W + 2;
    localparam int ACC_B     = SAMPLE_WIDTH + SUM_FRAC + 2;
    localparam int ACC_W     = (ACC_A > ACC_B) ? ACC_A : ACC_B;

    localparam logic signed [ACC_W-1:0] HALF_FB = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] HALF_FF = ACC_W'(1) <<< (SUM_FRAC - 1);
    localparam logic signed [ACC_W-1:0] W_MAX   = (ACC_W'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] W_MIN   = -W_MAX - 1;
    localparam logic signed [ACC_W-1:0] Y_MAX   = (ACC_W'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam logic signed [ACC_W-1:0] Y_MIN   = -Y_MAX - 1;

    logic signed [COEF_WIDTH-1:0]   coef_op;
    logic signed [STATE_WIDTH-1:0]  state_op;
    logic signed [PROD_W-1:0]       prod_next, prod_reg;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [ACC_W-1:0]        fb_shifted, ff_shifted;
    logic signed [STATE_WIDTH-1:0]  w_sat;
    logic                           w_ov;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_ov;
    logic signed [STATE_WIDTH-1:0]  w_reg, w1_reg, w2_reg;
    logic                           ov_w_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic                           overflow_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_A1W1: begin coef_op = a1; state_op = w1_reg; end
            MUL_A2W2: begin coef_op = a2; state_op = w2_reg; end
            MUL_B1W1: begin coef_op = b1; state_op = w1_reg; end
            MUL_B2W2: begin coef_op = b2; state_op = w2_reg; end
            MUL_B0W:  begin coef_op = b0; state_op = w_reg;  end
            default:  begin coef_op = a1; state_op = w1_reg; end
        endcase
    end

    assign prod_next = coef_op * state_op;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        case (cmd.acc_op)
            ACC_LOAD_X:        acc_next = (ACC_W'(sample_in) <<< SUM_FRAC) + HALF_FB;
            ACC_SUB:           acc_next = acc_reg - prod_ext;
            ACC_LOAD_HALF_ADD: acc_next = HALF_FF + prod_ext;
            ACC_ADD:           acc_next = acc_reg + prod_ext;
            default:           acc_next = acc_reg;
        endcase
    end

    // Feedback sum rounded to Q.8 and clamped to the delay word range.
    assign fb_shifted = acc_reg >>> COEF_FRAC;

    always_comb
    begin
        w_ov  = 1'b0;
        w_sat = fb_shifted[STATE_WIDTH-1:0];
        if (fb_shifted > W_MAX)
        begin
            w_ov  = 1'b1;
            w_sat = W_MAX[STATE_WIDTH-1:0];
        end
        else if (fb_shifted < W_MIN)
        begin
            w_ov  = 1'b1;
            w_sat = W_MIN[STATE_WIDTH-1:0];
        end
    end

    // Forward sum rounded to an integer and clamped to the sample range.
    assign ff_shifted = acc_reg >>> SUM_FRAC;

    always_comb
    begin
        y_ov  = 1'b0;
        y_sat = ff_shifted[SAMPLE_WIDTH-1:0];
        if (ff_shifted > Y_MAX)
        begin
            y_ov  = 1'b1;
            y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (ff_shifted < Y_MIN)
        begin
            y_ov  = 1'b1;
            y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.w_load)
        begin
            w_reg    <= w_sat;
            ov_w_reg <= w_ov;
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= y_sat;
            overflow_reg   <= y_ov || ov_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (cmd.out_load)
        begin
            w2_reg <= w1_reg;
            w1_reg <= w_reg;
        end
    end

    assign sample_out = sample_out_reg;
    assign overflow   = overflow_reg;

endmodule

// ----- hw/rtl/iir_biquad_df2_filter.sv -----
// ============================================================================
// iir_biquad_df2_filter - second-order IIR filter, direct form II
// Filters a stream of signed samples with programmable Q2.14 coefficients,
// a saturating Q24.8 delay line and a rounded, saturated output.
// ============================================================================
//
//   Channel   Direction  Carries                          Handshake
//   in_ch     sink       sample_in                        valid / ready
//   out_ch    source     sample_out, overflow             valid / ready
//   APB       slave      a1, a2, b0, b1, b2 (word 0..4)   psel / penable
//
// When the result is taken promptly, each word steps the sequencer through
// S_FB2, S_FBSUM, S_WSAT, S_FF0, S_FFLAST and S_OUT before the next word is
// accepted: the single shared multiplier forms the five products one per cycle,
// the first in the accepting cycle, and out_ch.valid rises with the result.
// Reset (rst_n, asynchronous) clears the delay line and the sequencer and
// restores the default coefficients. A stalled output register holds the
// sequencer in its output cycle; no new word is taken until the result moves.
//
module iir_biquad_df2_filter #(
    parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = ibq_pkg::COEF_WIDTH_DEF,
    parameter int STATE_WIDTH  = ibq_pkg::STATE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ibq_in_if.sink                             in_ch,
    ibq_out_if.source                          out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ibq_pkg::PADDR_WIDTH-1:0]    paddr,
    input  logic [ibq_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic [ibq_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                               pready
);
    import ibq_pkg::*;

    // Default coefficients rescaled to the configured coefficient width.
    localparam logic signed [COEF_WIDTH-1:0] A1_RST = COEF_WIDTH'(scale_coef(A1_RESET, COEF_WIDTH));
    localparam logic signed [COEF_WIDTH-1:0] A2_RST = COEF_WIDTH'(scale_coef(A2_RESET, COEF_WIDTH));
    localparam logic signed [COEF_WIDTH-1:0] B0_RST = COEF_WIDTH'(scale_coef(B0_RESET, COEF_WIDTH));
    localparam logic signed [COEF_WIDTH-1:0] B1_RST = COEF_WIDTH'(scale_coef(B1_RESET, COEF_WIDTH));
    localparam logic signed [COEF_WIDTH-1:0] B2_RST = COEF_WIDTH'(scale_coef(B2_RESET, COEF_WIDTH));
    localparam int PAD_W = CFG_DATA_WIDTH - COEF_WIDTH;

    logic signed [COEF_WIDTH-1:0] feedback_first_reg;
    logic signed [COEF_WIDTH-1:0] feedback_second_reg;
    logic signed [COEF_WIDTH-1:0] forward_zero_reg;
    logic signed [COEF_WIDTH-1:0] forward_first_reg;
    logic signed [COEF_WIDTH-1:0] forward_second_reg;
    logic                         cfg_write;
    logic [2:0]                   cfg_index;
    logic [COEF_WIDTH-1:0]        cfg_value;
    ibq_cmd_t                     cmd;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land in the access phase; pready is
    // tied high, so every transfer completes without wait states. Writes to an
    // unused word address are dropped and read back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[PADDR_WIDTH-1:2];
    assign cfg_value = pwdata[COEF_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_first_reg  <= A1_RST;
            feedback_second_reg <= A2_RST;
            forward_zero_reg    <= B0_RST;
            forward_first_reg   <= B1_RST;
            forward_second_reg  <= B2_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FEEDBACK_FIRST:  feedback_first_reg  <= cfg_value;
                REG_FEEDBACK_SECOND: feedback_second_reg <= cfg_value;
                REG_FORWARD_ZERO:    forward_zero_reg    <= cfg_value;
                REG_FORWARD_FIRST:   forward_first_reg   <= cfg_value;
                REG_FORWARD_SECOND:  forward_second_reg  <= cfg_value;
                default:
                begin
                end
            endcase
        end
    end

    // Read data is the raw coefficient word, zero-extended.
    always_comb
    begin
        unique case (cfg_index)
            REG_FEEDBACK_FIRST:  prdata = {{PAD_W{1'b0}}, feedback_first_reg};
            REG_FEEDBACK_SECOND: prdata = {{PAD_W{1'b0}}, feedback_second_reg};
            REG_FORWARD_ZERO:    prdata = {{PAD_W{1'b0}}, forward_zero_reg};
            REG_FORWARD_FIRST:   prdata = {{PAD_W{1'b0}}, forward_first_reg};
            REG_FORWARD_SECOND:  prdata = {{PAD_W{1'b0}}, forward_second_reg};
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: accepts a word when idle, steps through the products and
    // loads the output register once it is free.
    // ------------------------------------------------------------------
    ibq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // ------------------------------------------------------------------
    // Datapath: w = x - a1*w1 - a2*w2 (rounded, clamped), then
    // y = b0*w + b1*w1 + b2*w2 (rounded, clamped), then the delay shift.
    // ------------------------------------------------------------------
    ibq_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (in_ch.sample_in),
        .a1         (feedback_first_reg),
        .a2         (feedback_second_reg),
        .b0         (forward_zero_reg),
        .b1         (forward_first_reg),
        .b2         (forward_second_reg),
        .sample_out (out_ch.sample_out),
        .overflow   (out_ch.overflow)
    );

endmodule
